### design/gdfw_pkg.sv
`default_nettype none

package gdfw_pkg;

  // Fixed field widths
  localparam int VERT_W  = 5;
  localparam int VCNT_W  = 6;
  localparam int STAT_W  = 2;
  localparam int VMAP_W  = 1 << VERT_W;

  // Vertex limit ceiling and reset vertex count
  localparam int MAX_VERTICES   = 32;
  localparam int VCNT_RESET     = 32;

  // Storage defaults
  localparam int MAX_EDGES_DEF   = 128;
  localparam int STACK_DEPTH_DEF = 256;

  // Opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_WALK = 1'b1;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  // Walk sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_WT,
    S_SCAN,
    S_FLUSH,
    S_OVF
  } state_t;

endpackage

`default_nettype wire

### design/graph_depth_first_walk.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_opcode, in_from_vertex, in_to_vertex
// out_      output     out_valid / out_ready   out_visited_vertex, out_status, out_last
// cfg_      input      cfg_wr_en               cfg_wr_data (vertex count)
//
// An add-edge transaction completes on acceptance; its result is loaded into the output register.
// A walk starts by pushing the source, then for each stack pop reads the stack memory
// (S_POP_RD, S_POP_WT) and scans every stored edge (edge memory read through its single
// read port), then finishes: an empty-stack check and the final vertex, or on overflow
// the final vertex and the overflow result. Output stalls hold a pop that must release the
// held vertex, both finishing steps and the next input. Synchronous active-low reset
// clears the edge count, visited map, stack top and sequencer.
module graph_depth_first_walk #(
  parameter int MAX_EDGES   = gdfw_pkg::MAX_EDGES_DEF,
  parameter int STACK_DEPTH = gdfw_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_opcode,
  input  wire logic [gdfw_pkg::VERT_W-1:0] in_from_vertex,
  input  wire logic [gdfw_pkg::VERT_W-1:0] in_to_vertex,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [gdfw_pkg::VERT_W-1:0]      out_visited_vertex,
  output logic [gdfw_pkg::STAT_W-1:0]      out_status,
  output logic                             out_last,
  input  wire logic                        cfg_wr_en,
  input  wire logic [gdfw_pkg::VCNT_W-1:0] cfg_wr_data
);
  import gdfw_pkg::*;

  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int SC_W = $clog2(STACK_DEPTH + 1);

  // Sequencer and control state
  state_t              state_r, state_nxt;
  logic [VCNT_W-1:0]   vcnt_r;
  logic [EC_W-1:0]     edges_r, edges_nxt;
  logic [EC_W-1:0]     e_r, e_nxt;
  logic [SC_W-1:0]     top_r, top_nxt;
  logic [VMAP_W-1:0]   visited_r, visited_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [VERT_W-1:0]   pend_r, pend_nxt;
  logic [VERT_W-1:0]   s_r, s_nxt;
  logic                ovf_r, ovf_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [VERT_W-1:0]   out_vert_r, out_vert_nxt;
  logic [STAT_W-1:0]   out_stat_r, out_stat_nxt;
  logic                out_last_r, out_last_nxt;

  // Memories
  logic [2*VERT_W-1:0] edge_mem [MAX_EDGES];
  logic [2*VERT_W-1:0] edge_q;
  logic                edge_we;
  logic [EA_W-1:0]     edge_ra;
  logic [VERT_W-1:0]   stk_mem [STACK_DEPTH];
  logic [VERT_W-1:0]   stk_q;
  logic                stk_we;
  logic [SA_W-1:0]     stk_wa;
  logic [VERT_W-1:0]   stk_wd;
  logic [SA_W-1:0]     stk_ra;

  // Shared decode
  logic [VCNT_W-1:0]   lim;
  logic                out_free;
  logic                in_fire;
  logic                from_bad;
  logic                to_bad;
  logic                edges_full;
  logic                s_new;
  logic                pop_stall;
  logic [VERT_W-1:0]   e_tail;
  logic [VERT_W-1:0]   e_head;
  logic                e_match;
  logic                stk_full;
  logic [EC_W-1:0]     e_inc;
  logic                scan_more;

  assign lim        = (vcnt_r < VCNT_W'(MAX_VERTICES)) ? vcnt_r : VCNT_W'(MAX_VERTICES);
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign from_bad   = {1'b0, in_from_vertex} >= lim;
  assign to_bad     = {1'b0, in_to_vertex} >= lim;
  assign edges_full = edges_r >= EC_W'(MAX_EDGES);
  assign s_new      = !visited_r[stk_q];
  assign pop_stall  = s_new && pend_v_r && !out_free;
  assign e_tail     = edge_q[2*VERT_W-1:VERT_W];
  assign e_head     = edge_q[VERT_W-1:0];
  assign e_match    = (e_tail == s_r) && ({1'b0, e_head} < lim) && !visited_r[e_head];
  assign stk_full   = top_r == SC_W'(STACK_DEPTH);
  assign e_inc      = e_r + EC_W'(1);
  assign scan_more  = e_inc < edges_r;

  assign out_valid          = out_valid_r;
  assign out_visited_vertex = out_vert_r;
  assign out_status         = out_stat_r;
  assign out_last           = out_last_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_opcode == OP_WALK && !from_bad) state_nxt = S_POP_RD;
      end
      S_POP_RD: begin
        state_nxt = (top_r == '0) ? S_FLUSH : S_POP_WT;
      end
      S_POP_WT: begin
        if (!pop_stall) state_nxt = (edges_r == '0) ? S_POP_RD : S_SCAN;
      end
      S_SCAN: begin
        if (e_match && stk_full) state_nxt = S_FLUSH;
        else if (!scan_more)     state_nxt = S_POP_RD;
      end
      S_FLUSH: begin
        if (out_free) state_nxt = ovf_r ? S_OVF : S_IDLE;
      end
      S_OVF: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result loading
  always_comb begin
    edges_nxt     = edges_r;
    e_nxt         = e_r;
    top_nxt       = top_r;
    visited_nxt   = visited_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    s_nxt         = s_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_vert_nxt  = out_vert_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    edge_we       = 1'b0;
    edge_ra       = '0;
    stk_we        = 1'b0;
    stk_wa        = '0;
    stk_wd        = in_from_vertex;
    stk_ra        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_vert_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = ST_OK;
          if (in_opcode == OP_ADD) begin
            if (from_bad || to_bad) begin
              out_stat_nxt = ST_RANGE;
            end else if (edges_full) begin
              out_stat_nxt = ST_FULL;
            end else begin
              edge_we   = 1'b1;
              edges_nxt = edges_r + EC_W'(1);
            end
          end else if (from_bad) begin
            out_stat_nxt = ST_RANGE;
          end else begin
            // Start the walk: clear visited, push the source
            out_valid_nxt = out_valid_r && !out_ready;
            visited_nxt   = '0;
            stk_we        = 1'b1;
            stk_wa        = '0;
            stk_wd        = in_from_vertex;
            top_nxt       = SC_W'(1);
            pend_v_nxt    = 1'b0;
            ovf_nxt       = 1'b0;
          end
        end
      end
      S_POP_RD: begin
        if (top_r != '0) begin
          stk_ra  = SA_W'(top_r - SC_W'(1));
          top_nxt = top_r - SC_W'(1);
        end
      end
      S_POP_WT: begin
        // Keep reading the popped entry so a stall holds it
        stk_ra = top_r[SA_W-1:0];
        if (!pop_stall) begin
          s_nxt = stk_q;
          if (s_new) begin
            visited_nxt[stk_q] = 1'b1;
            pend_nxt           = stk_q;
            pend_v_nxt         = 1'b1;
            // Release the previously held vertex; it is not the last one
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_vert_nxt  = pend_r;
              out_stat_nxt  = ST_OK;
              out_last_nxt  = 1'b0;
            end
          end
          e_nxt   = '0;
          edge_ra = '0;
        end
      end
      S_SCAN: begin
        if (e_match && stk_full) begin
          ovf_nxt = 1'b1;
          top_nxt = '0;
        end else begin
          if (e_match) begin
            stk_we  = 1'b1;
            stk_wa  = top_r[SA_W-1:0];
            stk_wd  = e_head;
            top_nxt = top_r + SC_W'(1);
          end
          if (scan_more) begin
            e_nxt   = e_inc;
            edge_ra = e_inc[EA_W-1:0];
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vert_nxt  = pend_r;
          out_stat_nxt  = ST_OK;
          out_last_nxt  = !ovf_r;
          pend_v_nxt    = 1'b0;
        end
      end
      S_OVF: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vert_nxt  = '0;
          out_stat_nxt  = ST_OVERFLOW;
          out_last_nxt  = 1'b1;
          ovf_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcnt_r      <= VCNT_W'(VCNT_RESET);
      edges_r     <= '0;
      top_r       <= '0;
      visited_r   <= '0;
      pend_v_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) vcnt_r <= cfg_wr_data;
      edges_r     <= edges_nxt;
      top_r       <= top_nxt;
      visited_r   <= visited_nxt;
      pend_v_r    <= pend_v_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    pend_r     <= pend_nxt;
    s_r        <= s_nxt;
    out_vert_r <= out_vert_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  // Edge memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edges_r[EA_W-1:0]] <= {in_from_vertex, in_to_vertex};
    edge_q <= edge_mem[edge_ra];
  end

  // Stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q <= stk_mem[stk_ra];
  end

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= SC_W'(STACK_DEPTH))
    else $error("stack top beyond depth");

  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= EC_W'(MAX_EDGES))
    else $error("edge count beyond table size");

  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |-> pend_v_r)
    else $error("walk finished with no vertex held");

  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_fire && in_opcode == OP_WALK && !from_bad)
      |=> (visited_r == '0 && top_r == SC_W'(1)))
    else $error("walk did not start from a clear map with the source pushed");
`endif

endmodule

`default_nettype wire

### dv/tb_graph_depth_first_walk.sv
module tb_graph_depth_first_walk;
  timeunit 1ns;
  timeprecision 1ps;

  import gdfw_pkg::*;

  localparam int EDGE_SLOTS    = MAX_EDGES_DEF;
  localparam int STACK_SLOTS   = STACK_DEPTH_DEF;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 600;
  localparam int STALL_LIMIT   = 200000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic              op;
    logic [VERT_W-1:0] src;
    logic [VERT_W-1:0] dst;
  } graph_cmd_t;

  typedef struct packed {
    logic [VERT_W-1:0] vertex;
    logic [STAT_W-1:0] status;
    logic              last;
  } visit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = 1'b0;
  logic [VERT_W-1:0] in_from_vertex = '0;
  logic [VERT_W-1:0] in_to_vertex = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VERT_W-1:0] out_visited_vertex;
  logic [STAT_W-1:0] out_status;
  logic              out_last;
  logic              cfg_wr_en = 1'b0;
  logic [VCNT_W-1:0] cfg_wr_data = '0;

  // Shadow of the graph store, the walk and the vertex count
  logic [VERT_W-1:0] mdl_tail [EDGE_SLOTS];
  logic [VERT_W-1:0] mdl_head [EDGE_SLOTS];
  logic [VERT_W-1:0] mdl_stack [STACK_SLOTS];
  logic [VMAP_W-1:0] mdl_seen = '0;
  int                mdl_edge_cnt = 0;
  int                mdl_sp = 0;
  logic [VCNT_W-1:0] mdl_vcount = VCNT_W'(VCNT_RESET);

  graph_cmd_t cmd_queue [$];
  visit_t     expected_visits [$];

  int  in_idle_pct = 24;
  int  out_idle_pct = 78;
  int  in_accepts = 0;
  int  in_accepts_seen = 0;
  bit  drv_busy = 1'b0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;
  int  fail_count = 0;

  graph_depth_first_walk #(
    .MAX_EDGES  (EDGE_SLOTS),
    .STACK_DEPTH(STACK_SLOTS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_from_vertex    (in_from_vertex),
    .in_to_vertex      (in_to_vertex),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_visited_vertex(out_visited_vertex),
    .out_status        (out_status),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int vertex_limit();
    return (mdl_vcount < MAX_VERTICES) ? int'(mdl_vcount) : MAX_VERTICES;
  endfunction

  function automatic void push_visit(input logic [VERT_W-1:0] v, input logic [STAT_W-1:0] st,
                                     input logic lst);
    visit_t r;
    r.vertex = v;
    r.status = st;
    r.last   = lst;
    expected_visits.insert(expected_visits.size(), r);
  endfunction

  // Work out every result of one command and update the shadow state
  function automatic void dfs_predict(input logic op, input logic [VERT_W-1:0] src,
                                      input logic [VERT_W-1:0] dst);
    int     lim;
    int     e;
    int     s;
    int     h;
    bit     overflow;
    visit_t tail_r;
    lim = vertex_limit();
    if (op == OP_ADD) begin
      if (src >= lim || dst >= lim) begin
        push_visit('0, ST_RANGE, 1'b1);
      end else if (mdl_edge_cnt >= EDGE_SLOTS) begin
        push_visit('0, ST_FULL, 1'b1);
      end else begin
        mdl_tail[mdl_edge_cnt] = src;
        mdl_head[mdl_edge_cnt] = dst;
        mdl_edge_cnt++;
        push_visit('0, ST_OK, 1'b1);
      end
      return;
    end
    if (src >= lim) begin
      push_visit('0, ST_RANGE, 1'b1);
      return;
    end
    // Restart the walk from the source
    mdl_seen = '0;
    mdl_sp = 0;
    mdl_stack[mdl_sp] = src;
    mdl_sp++;
    overflow = 1'b0;
    while (mdl_sp > 0 && !overflow) begin
      mdl_sp--;
      s = int'(mdl_stack[mdl_sp]);
      if (s < lim) begin
        if (!mdl_seen[s]) begin
          mdl_seen[s] = 1'b1;
          push_visit(VERT_W'(s), ST_OK, 1'b0);
        end
        // Push unvisited successors in insertion order, skip stale heads
        for (e = 0; e < mdl_edge_cnt && !overflow; e++) begin
          h = int'(mdl_head[e]);
          if (mdl_tail[e] == VERT_W'(s) && h < lim && !mdl_seen[h]) begin
            if (mdl_sp >= STACK_SLOTS) begin
              overflow = 1'b1;
            end else begin
              mdl_stack[mdl_sp] = VERT_W'(h);
              mdl_sp++;
            end
          end
        end
      end
    end
    if (overflow) begin
      mdl_sp = 0;
      push_visit('0, ST_OVERFLOW, 1'b1);
    end else begin
      tail_r = expected_visits.pop_back();
      tail_r.last = 1'b1;
      expected_visits.insert(expected_visits.size(), tail_r);
    end
  endfunction

  // Predict on each accepted command transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      dfs_predict(in_opcode, in_from_vertex, in_to_vertex);
      in_accepts++;
    end
  end

  // Drive commands from the pending queue; hold valid until accepted
  always @(negedge clk) begin
    graph_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (drv_busy && in_accepts != in_accepts_seen) begin
        in_accepts_seen = in_accepts;
        drv_busy = 1'b0;
      end
      if (!drv_busy && cmd_queue.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        c = cmd_queue.pop_front();
        in_opcode <= c.op;
        in_from_vertex <= c.src;
        in_to_vertex <= c.dst;
        drv_busy = 1'b1;
      end
      in_valid <= drv_busy;
    end
  end

  // Drive result ready, with random idling and an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    visit_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_visits.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: vertex %0d status %0d last %0d",
                   out_visited_vertex, out_status, out_last);
      end else begin
        exp_r = expected_visits.pop_front();
        if (out_visited_vertex !== exp_r.vertex || out_status !== exp_r.status ||
            out_last !== exp_r.last) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: expected vertex %0d status %0d last %0d, got %0d %0d %0d",
                     exp_r.vertex, exp_r.status, exp_r.last,
                     out_visited_vertex, out_status, out_last);
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic queue_cmd(input logic op, input logic [VERT_W-1:0] src,
                           input logic [VERT_W-1:0] dst);
    graph_cmd_t c;
    c.op  = op;
    c.src = src;
    c.dst = dst;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  // Hold until every command is taken and every result has come back
  task automatic wait_idle();
    while (cmd_queue.size() > 0 || drv_busy || expected_visits.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [VCNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mdl_vcount = value;
  endtask

  // Mostly in-range edge loads followed by a walk, with some out-of-range noise
  task automatic queue_random_traffic(input int n_items);
    int                lim;
    int                queued;
    int                n_adds;
    int                k;
    logic [VERT_W-1:0] a;
    logic [VERT_W-1:0] b;
    lim = vertex_limit();
    queued = 0;
    while (queued < n_items) begin
      n_adds = $urandom_range(8, 2);
      for (k = 0; k < n_adds; k++) begin
        if ($urandom_range(9) == 0) begin
          a = VERT_W'($urandom);
          b = VERT_W'($urandom);
        end else begin
          a = VERT_W'($urandom_range(lim - 1));
          b = VERT_W'($urandom_range(lim - 1));
        end
        queue_cmd(OP_ADD, a, b);
      end
      if ($urandom_range(9) == 0)
        a = VERT_W'($urandom);
      else
        a = VERT_W'($urandom_range(lim - 1));
      queue_cmd(OP_WALK, a, VERT_W'($urandom));
      queued += n_adds + 1;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: small graph with a cycle, a self-loop, a duplicate edge and a leaf
    cfg_write(6'd32);
    queue_cmd(OP_ADD, 5'd0, 5'd1);
    queue_cmd(OP_ADD, 5'd1, 5'd2);
    queue_cmd(OP_ADD, 5'd2, 5'd0);
    queue_cmd(OP_ADD, 5'd0, 5'd31);
    queue_cmd(OP_ADD, 5'd31, 5'd31);
    queue_cmd(OP_ADD, 5'd31, 5'd0);
    queue_cmd(OP_ADD, 5'd1, 5'd2);
    queue_cmd(OP_ADD, 5'd2, 5'd5);
    queue_cmd(OP_WALK, 5'd0, 5'd31);
    queue_cmd(OP_WALK, 5'd31, 5'd0);
    queue_cmd(OP_WALK, 5'd5, 5'd21);
    queue_cmd(OP_WALK, 5'd10, 5'd10);
    wait_idle();

    // Lowered count: range errors on both ends, stale heads skipped
    cfg_write(6'd4);
    queue_cmd(OP_ADD, 5'd3, 5'd4);
    queue_cmd(OP_ADD, 5'd4, 5'd0);
    queue_cmd(OP_ADD, 5'd3, 5'd3);
    queue_cmd(OP_WALK, 5'd0, 5'd0);
    queue_cmd(OP_WALK, 5'd4, 5'd0);
    wait_idle();

    // Zero count rejects everything
    cfg_write(6'd0);
    queue_cmd(OP_ADD, 5'd0, 5'd0);
    queue_cmd(OP_WALK, 5'd0, 5'd0);
    wait_idle();

    cfg_write(6'd1);
    queue_cmd(OP_ADD, 5'd0, 5'd0);
    queue_cmd(OP_WALK, 5'd0, 5'd0);
    wait_idle();

    // Count above the ceiling clamps to the ceiling
    cfg_write(6'd63);
    queue_cmd(OP_WALK, 5'd31, 5'd0);
    queue_cmd(OP_ADD, 5'd31, 5'd30);
    wait_idle();

    // Random, sender idles lightly and receiver heavily; table fills here
    cfg_write(6'd32);
    hold_req++;
    queue_random_traffic(75);
    wait_idle();
    queue_random_traffic(75);
    wait_idle();

    // Random, the other way round
    in_idle_pct = 78;
    out_idle_pct = 24;
    cfg_write(6'd12);
    queue_random_traffic(75);
    wait_idle();
    cfg_write(6'd20);
    queue_random_traffic(75);
    wait_idle();

    // Random, no idling, with a long receiver hold-off at the start
    in_idle_pct = 0;
    out_idle_pct = 0;
    cfg_write(6'd63);
    hold_req++;
    queue_random_traffic(150);
    wait_idle();

    if (fail_count == 0 && expected_visits.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
